[sv/shk_pkg.sv]
// ============================================================================
// shk_pkg: shared constants for the static hash table unit
// Holds the field widths, result codes and parameter defaults.
// ============================================================================
package shk_pkg;

    // Field widths fixed by the interface.
    localparam int KEY_W      = 31;
    localparam int PAYLOAD_W  = 64;
    localparam int STATUS_W   = 2;
    localparam int BLKNUM_W   = 8;
    localparam int BLKREAD_W  = 9;
    localparam int CFG_W      = 7;

    // Bucket count after reset.
    localparam int RESET_BUCKETS = 16;

    // Parameter defaults.
    localparam int DEF_MAX_BUCKETS       = 64;
    localparam int DEF_MAX_BLOCKS        = 256;
    localparam int DEF_RECORDS_PER_BLOCK = 8;
    localparam int DEF_PAYLOAD_BITS      = 64;

    // Result status codes.
    localparam logic [STATUS_W-1:0] ST_INSERTED  = 2'd0;
    localparam logic [STATUS_W-1:0] ST_FOUND     = 2'd1;
    localparam logic [STATUS_W-1:0] ST_NOT_FOUND = 2'd2;
    localparam logic [STATUS_W-1:0] ST_FULL      = 2'd3;

    // Action codes.
    localparam logic ACT_INSERT = 1'b0;
    localparam logic ACT_LOOKUP = 1'b1;

endpackage

[sv/shk_fifo.sv]
// ============================================================================
// shk_fifo: two-entry queue between the front and back parts
// Holds classified items so that either side can stall on its own.
// ============================================================================
module shk_fifo #(
    parameter int W = 8
) (
    input  logic         i_clk,
    input  logic         i_rst_n,
    input  logic         i_push,
    input  logic [W-1:0] i_data,
    output logic         o_full,
    input  logic         i_pop,
    output logic         o_valid,
    output logic [W-1:0] o_data
);

    logic [W-1:0] r_mem [2];
    logic         r_wptr;
    logic         r_rptr;
    logic [1:0]   r_count;

    assign o_full  = (r_count == 2'd2);
    assign o_valid = (r_count != 2'd0);
    assign o_data  = r_mem[r_rptr];

    // Storage is written at the write pointer.
    always_ff @(posedge i_clk) begin
        if (i_push) begin
            r_mem[r_wptr] <= i_data;
        end
    end

    // Pointers and occupancy.
    always_ff @(posedge i_clk) begin
        if (!i_rst_n) begin
            r_wptr  <= 1'b0;
            r_rptr  <= 1'b0;
            r_count <= 2'd0;
        end else begin
            if (i_push) begin
                r_wptr <= ~r_wptr;
            end
            if (i_pop) begin
                r_rptr <= ~r_rptr;
            end
            if (i_push && !i_pop) begin
                r_count <= r_count + 2'd1;
            end else if (!i_push && i_pop) begin
                r_count <= r_count - 2'd1;
            end
        end
    end

endmodule

[sv/shk_front.sv]
// ============================================================================
// shk_front: input acceptance and bucket classification
// Takes an item and finds its bucket with a bit-serial remainder unit.
// ============================================================================
module shk_front #(
    parameter int MAX_BUCKETS  = shk_pkg::DEF_MAX_BUCKETS,
    parameter int PAYLOAD_BITS = shk_pkg::DEF_PAYLOAD_BITS,
    parameter int BW           = 7,
    parameter int QW           = 8
) (
    input  logic                       i_clk,
    input  logic                       i_rst_n,
    input  logic [BW-1:0]              i_buckets,
    input  logic                       i_in_valid,
    output logic                       o_in_stall,
    input  logic                       i_action,
    input  logic [shk_pkg::KEY_W-1:0]  i_record_key,
    input  logic [shk_pkg::PAYLOAD_W-1:0] i_record_payload,
    output logic                       o_push,
    output logic [QW-1:0]              o_data,
    input  logic                       i_full
);

    localparam int HW  = $clog2(MAX_BUCKETS > 1 ? MAX_BUCKETS : 2);
    localparam int RW  = BW + 1;
    localparam int CNW = $clog2(shk_pkg::KEY_W + 1);

    localparam logic [1:0] F_IDLE = 2'd0;
    localparam logic [1:0] F_DIV  = 2'd1;
    localparam logic [1:0] F_PUSH = 2'd2;

    logic [1:0]                    r_state;
    logic                          r_act;
    logic [shk_pkg::KEY_W-1:0]     r_key;
    logic [shk_pkg::KEY_W-1:0]     r_shift;
    logic [PAYLOAD_BITS-1:0]       r_pay;
    logic [RW-1:0]                 r_rem;
    logic [CNW-1:0]                r_cnt;
    logic [RW-1:0]                 w_trial;

    assign o_in_stall = (r_state != F_IDLE);
    assign o_push     = (r_state == F_PUSH) && !i_full;
    assign o_data     = {r_act, r_key, r_pay, HW'(r_rem)};

    // One remainder bit per cycle: shift in the next key bit, subtract if it fits.
    assign w_trial = {r_rem[RW-2:0], r_shift[shk_pkg::KEY_W-1]};

    always_ff @(posedge i_clk) begin
        if (!i_rst_n) begin
            r_state <= F_IDLE;
        end else begin
            case (r_state)
                F_IDLE: begin
                    if (i_in_valid) begin
                        r_state <= F_DIV;
                    end
                end
                F_DIV: begin
                    if (r_cnt == CNW'(shk_pkg::KEY_W - 1)) begin
                        r_state <= F_PUSH;
                    end
                end
                F_PUSH: begin
                    if (!i_full) begin
                        r_state <= F_IDLE;
                    end
                end
                default: r_state <= F_IDLE;
            endcase
        end
    end

    // Item capture and remainder datapath.
    always_ff @(posedge i_clk) begin
        if (r_state == F_IDLE && i_in_valid) begin
            r_act   <= i_action;
            r_key   <= i_record_key;
            r_shift <= i_record_key;
            r_pay   <= PAYLOAD_BITS'(i_record_payload);
            r_rem   <= '0;
            r_cnt   <= '0;
        end else if (r_state == F_DIV) begin
            r_shift <= {r_shift[shk_pkg::KEY_W-2:0], 1'b0};
            r_cnt   <= r_cnt + CNW'(1);
            if (w_trial >= {1'b0, i_buckets}) begin
                r_rem <= w_trial - {1'b0, i_buckets};
            end else begin
                r_rem <= w_trial;
            end
        end
    end

endmodule

[sv/shk_back.sv]
// ============================================================================
// shk_back: table execution
// Carries out inserts and chain-walking lookups over the table memories.
// ============================================================================
module shk_back #(
    parameter int MAX_BUCKETS       = shk_pkg::DEF_MAX_BUCKETS,
    parameter int MAX_BLOCKS        = shk_pkg::DEF_MAX_BLOCKS,
    parameter int RECORDS_PER_BLOCK = shk_pkg::DEF_RECORDS_PER_BLOCK,
    parameter int PAYLOAD_BITS      = shk_pkg::DEF_PAYLOAD_BITS,
    parameter int QW                = 8,
    parameter int BIU_W             = 9,
    parameter int BIU_RESET         = 17
) (
    input  logic                          i_clk,
    input  logic                          i_rst_n,
    input  logic                          i_clear,
    input  logic [BIU_W-1:0]              i_biu_init,
    input  logic                          i_q_valid,
    input  logic [QW-1:0]                 i_q_data,
    output logic                          o_q_pop,
    output logic                          o_out_valid,
    input  logic                          i_out_stall,
    output logic [shk_pkg::STATUS_W-1:0]  o_status,
    output logic [shk_pkg::BLKNUM_W-1:0]  o_block_number,
    output logic [shk_pkg::BLKREAD_W-1:0] o_blocks_read,
    output logic [shk_pkg::PAYLOAD_W-1:0] o_found_payload
);

    localparam int HW   = $clog2(MAX_BUCKETS > 1 ? MAX_BUCKETS : 2);
    localparam int BLKW = $clog2(MAX_BLOCKS);
    localparam int FW   = $clog2(RECORDS_PER_BLOCK + 1);
    localparam int NS   = MAX_BLOCKS * RECORDS_PER_BLOCK;
    localparam int SAW  = $clog2(NS);
    localparam int CW   = $clog2(MAX_BLOCKS + 1);
    localparam int KW   = shk_pkg::KEY_W;

    localparam logic [3:0] S_IDLE  = 4'd0;
    localparam logic [3:0] S_ITAIL = 4'd1;
    localparam logic [3:0] S_IFILL = 4'd2;
    localparam logic [3:0] S_INEW  = 4'd3;
    localparam logic [3:0] S_LBLK  = 4'd4;
    localparam logic [3:0] S_LHDR  = 4'd5;
    localparam logic [3:0] S_LRD   = 4'd6;
    localparam logic [3:0] S_LCMP  = 4'd7;

    // Table memories.
    logic [BLKW-1:0]         tail_mem [MAX_BUCKETS];
    logic [FW-1:0]           fill_mem [MAX_BLOCKS];
    logic [BLKW-1:0]         next_mem [MAX_BLOCKS];
    logic [KW-1:0]           key_mem  [NS];
    logic [PAYLOAD_BITS-1:0] pay_mem  [NS];

    logic [MAX_BUCKETS-1:0]  r_tvalid;
    logic [MAX_BLOCKS-1:0]   r_bvalid;
    logic [BLKW-1:0]         r_tail_q;
    logic [FW-1:0]           r_fill_q;
    logic [BLKW-1:0]         r_next_q;
    logic [KW-1:0]           r_key_q;
    logic [PAYLOAD_BITS-1:0] r_pay_q;

    // Item and walk state.
    logic [3:0]              r_state;
    logic [KW-1:0]           r_key;
    logic [PAYLOAD_BITS-1:0] r_pay;
    logic [HW-1:0]           r_h;
    logic [BLKW-1:0]         r_blk;
    logic [FW-1:0]           r_fill;
    logic [BLKW-1:0]         r_next;
    logic [FW-1:0]           r_j;
    logic [CW-1:0]           r_count;
    logic [BIU_W-1:0]        r_biu;

    // Result register.
    logic                          r_ovalid;
    logic [shk_pkg::STATUS_W-1:0]  r_ostatus;
    logic [BLKW-1:0]               r_oblk;
    logic [CW-1:0]                 r_oread;
    logic [PAYLOAD_BITS-1:0]       r_opay;

    // Fields of the queue entry.
    logic                    w_q_act;
    logic [KW-1:0]           w_q_key;
    logic [PAYLOAD_BITS-1:0] w_q_pay;
    logic [HW-1:0]           w_q_h;

    // Memory control.
    logic                    w_tail_re, w_tail_we;
    logic [HW-1:0]           w_tail_ra;
    logic [BLKW-1:0]         w_tail_wd;
    logic                    w_hdr_re;
    logic [BLKW-1:0]         w_hdr_ra;
    logic                    w_fill_we;
    logic [BLKW-1:0]         w_fill_wa;
    logic [FW-1:0]           w_fill_wd;
    logic                    w_next_we;
    logic [BLKW-1:0]         w_next_wa;
    logic [BLKW-1:0]         w_next_wd;
    logic                    w_slot_re, w_slot_we;
    logic [SAW-1:0]          w_slot_ra, w_slot_wa;

    // Derived values.
    logic [BLKW-1:0]         w_tail_blk;
    logic [FW-1:0]           w_cur_fill;
    logic [BLKW-1:0]         w_cur_next;
    logic                    w_start;

    assign {w_q_act, w_q_key, w_q_pay, w_q_h} = i_q_data;

    assign w_start = (r_state == S_IDLE) && i_q_valid && !r_ovalid;
    assign o_q_pop = w_start;

    assign w_tail_blk = r_tvalid[r_h] ? r_tail_q : BLKW'(32'(r_h) + 1);
    assign w_cur_fill = r_bvalid[r_blk] ? r_fill_q : '0;
    assign w_cur_next = r_bvalid[r_blk] ? r_next_q : '0;

    assign o_out_valid     = r_ovalid;
    assign o_status        = r_ostatus;
    assign o_block_number  = shk_pkg::BLKNUM_W'(r_oblk);
    assign o_blocks_read   = shk_pkg::BLKREAD_W'(r_oread);
    assign o_found_payload = shk_pkg::PAYLOAD_W'(r_opay);

    // Memory addresses and write enables for each state.
    always_comb begin
        w_tail_re = 1'b0;
        w_tail_ra = w_q_h;
        w_tail_we = 1'b0;
        w_tail_wd = r_biu[BLKW-1:0];
        w_hdr_re  = 1'b0;
        w_hdr_ra  = r_blk;
        w_fill_we = 1'b0;
        w_fill_wa = r_blk;
        w_fill_wd = w_cur_fill + FW'(1);
        w_next_we = 1'b0;
        w_next_wa = r_blk;
        w_next_wd = '0;
        w_slot_re = 1'b0;
        w_slot_ra = SAW'(32'(r_blk) * RECORDS_PER_BLOCK + 32'(r_j));
        w_slot_we = 1'b0;
        w_slot_wa = SAW'(32'(r_blk) * RECORDS_PER_BLOCK + 32'(w_cur_fill));
        case (r_state)
            S_IDLE: begin
                w_tail_re = w_start;
            end
            S_ITAIL: begin
                w_hdr_re = 1'b1;
                w_hdr_ra = w_tail_blk;
            end
            S_IFILL: begin
                if (w_cur_fill < FW'(RECORDS_PER_BLOCK)) begin
                    w_fill_we = 1'b1;
                    w_slot_we = 1'b1;
                    w_next_we = !r_bvalid[r_blk];
                end else if (32'(r_biu) < MAX_BLOCKS) begin
                    // Link a fresh block behind the full tail.
                    w_next_we = 1'b1;
                    w_next_wd = r_biu[BLKW-1:0];
                    w_tail_we = 1'b1;
                end
            end
            S_INEW: begin
                w_fill_we = 1'b1;
                w_fill_wd = FW'(1);
                w_next_we = 1'b1;
                w_slot_we = 1'b1;
                w_slot_wa = SAW'(32'(r_blk) * RECORDS_PER_BLOCK);
            end
            S_LBLK: begin
                w_hdr_re = 1'b1;
            end
            S_LRD: begin
                w_slot_re = 1'b1;
            end
            default: begin
            end
        endcase
    end

    // Bucket tail memory.
    always_ff @(posedge i_clk) begin
        if (w_tail_we) begin
            tail_mem[r_h] <= w_tail_wd;
        end
        if (w_tail_re) begin
            r_tail_q <= tail_mem[w_tail_ra];
        end
    end

    // Block header memories: fill count and chain link.
    always_ff @(posedge i_clk) begin
        if (w_fill_we) begin
            fill_mem[w_fill_wa] <= w_fill_wd;
        end
        if (w_hdr_re) begin
            r_fill_q <= fill_mem[w_hdr_ra];
        end
    end

    always_ff @(posedge i_clk) begin
        if (w_next_we) begin
            next_mem[w_next_wa] <= w_next_wd;
        end
        if (w_hdr_re) begin
            r_next_q <= next_mem[w_hdr_ra];
        end
    end

    // Record slot memories.
    always_ff @(posedge i_clk) begin
        if (w_slot_we) begin
            key_mem[w_slot_wa] <= r_key;
            pay_mem[w_slot_wa] <= r_pay;
        end
        if (w_slot_re) begin
            r_key_q <= key_mem[w_slot_ra];
            r_pay_q <= pay_mem[w_slot_ra];
        end
    end

    // Valid bits stand in for the cleared tail and header tables.
    always_ff @(posedge i_clk) begin
        if (!i_rst_n || i_clear) begin
            r_tvalid <= '0;
            r_bvalid <= '0;
        end else begin
            if (w_tail_we) begin
                r_tvalid[r_h] <= 1'b1;
            end
            if (w_fill_we) begin
                r_bvalid[w_fill_wa] <= 1'b1;
            end
        end
    end

    // Block bump counter.
    always_ff @(posedge i_clk) begin
        if (!i_rst_n) begin
            r_biu <= BIU_W'(BIU_RESET);
        end else if (i_clear) begin
            r_biu <= i_biu_init;
        end else if (w_tail_we) begin
            r_biu <= r_biu + BIU_W'(1);
        end
    end

    // Sequencer.
    always_ff @(posedge i_clk) begin
        if (!i_rst_n) begin
            r_state <= S_IDLE;
        end else begin
            case (r_state)
                S_IDLE: begin
                    if (w_start) begin
                        r_state <= (w_q_act == shk_pkg::ACT_INSERT) ? S_ITAIL : S_LBLK;
                    end
                end
                S_ITAIL: r_state <= S_IFILL;
                S_IFILL: begin
                    if (w_tail_we) begin
                        r_state <= S_INEW;
                    end else begin
                        r_state <= S_IDLE;
                    end
                end
                S_INEW:  r_state <= S_IDLE;
                S_LBLK:  r_state <= S_LHDR;
                S_LHDR: begin
                    if (w_cur_fill != '0) begin
                        r_state <= S_LRD;
                    end else if (w_cur_next != '0) begin
                        r_state <= S_LBLK;
                    end else begin
                        r_state <= S_IDLE;
                    end
                end
                S_LRD:   r_state <= S_LCMP;
                S_LCMP: begin
                    if (r_key_q == r_key) begin
                        r_state <= S_IDLE;
                    end else if (r_j + FW'(1) != r_fill) begin
                        r_state <= S_LRD;
                    end else if (r_next != '0) begin
                        r_state <= S_LBLK;
                    end else begin
                        r_state <= S_IDLE;
                    end
                end
                default: r_state <= S_IDLE;
            endcase
        end
    end

    // Walk datapath.
    always_ff @(posedge i_clk) begin
        case (r_state)
            S_IDLE: begin
                if (w_start) begin
                    r_key   <= w_q_key;
                    r_pay   <= w_q_pay;
                    r_h     <= w_q_h;
                    r_blk   <= BLKW'(32'(w_q_h) + 1);
                    r_count <= '0;
                end
            end
            S_ITAIL: r_blk <= w_tail_blk;
            S_IFILL: begin
                if (w_tail_we) begin
                    r_blk <= r_biu[BLKW-1:0];
                end
            end
            S_LHDR: begin
                r_fill  <= w_cur_fill;
                r_next  <= w_cur_next;
                r_j     <= '0;
                r_count <= r_count + CW'(1);
                if (w_cur_fill == '0) begin
                    r_blk <= w_cur_next;
                end
            end
            S_LCMP: begin
                r_j <= r_j + FW'(1);
                if (r_j + FW'(1) == r_fill) begin
                    r_blk <= r_next;
                end
            end
            default: begin
            end
        endcase
    end

    // Result register: loaded when an item finishes, emptied when taken.
    always_ff @(posedge i_clk) begin
        if (!i_rst_n) begin
            r_ovalid <= 1'b0;
        end else if (r_ovalid && !i_out_stall) begin
            r_ovalid <= 1'b0;
        end else begin
            case (r_state)
                S_IFILL: begin
                    if (!w_tail_we) begin
                        r_ovalid <= 1'b1;
                    end
                end
                S_INEW: r_ovalid <= 1'b1;
                S_LHDR: begin
                    if (w_cur_fill == '0 && w_cur_next == '0) begin
                        r_ovalid <= 1'b1;
                    end
                end
                S_LCMP: begin
                    if (r_key_q == r_key ||
                        (r_j + FW'(1) == r_fill && r_next == '0)) begin
                        r_ovalid <= 1'b1;
                    end
                end
                default: begin
                end
            endcase
        end
    end

    always_ff @(posedge i_clk) begin
        case (r_state)
            S_IFILL: begin
                r_oread <= '0;
                r_opay  <= '0;
                if (w_fill_we) begin
                    r_ostatus <= shk_pkg::ST_INSERTED;
                    r_oblk    <= r_blk;
                end else begin
                    r_ostatus <= shk_pkg::ST_FULL;
                    r_oblk    <= '0;
                end
            end
            S_INEW: begin
                r_ostatus <= shk_pkg::ST_INSERTED;
                r_oblk    <= r_blk;
                r_oread   <= '0;
                r_opay    <= '0;
            end
            S_LHDR: begin
                r_ostatus <= shk_pkg::ST_NOT_FOUND;
                r_oblk    <= '0;
                r_oread   <= '0;
                r_opay    <= '0;
            end
            S_LCMP: begin
                r_oblk <= '0;
                if (r_key_q == r_key) begin
                    r_ostatus <= shk_pkg::ST_FOUND;
                    r_oread   <= r_count;
                    r_opay    <= r_pay_q;
                end else begin
                    r_ostatus <= shk_pkg::ST_NOT_FOUND;
                    r_oread   <= '0;
                    r_opay    <= '0;
                end
            end
            default: begin
            end
        endcase
    end

endmodule

[sv/static_hash_overflow_chain_table_unit.sv]
// ============================================================================
// static_hash_overflow_chain_table_unit: hash table with overflow chains
// Records live in fixed-size blocks; each bucket grows a chain of blocks.
// ============================================================================
//  Channel  | Handshake                 | Payload
//  ---------+---------------------------+-----------------------------------
//  in       | i_in_valid / o_in_stall   | action, record_key, record_payload
//  out      | o_out_valid / i_out_stall | status, block_number, blocks_read,
//           |                           | found_payload
//  cfg      | i_cfg_we                  | i_cfg_wdata (bucket count)
//
// The front part forms the bit-serial key remainder and takes no new item
// until it has pushed the last. An insert runs through S_ITAIL, S_IFILL and,
// for a fresh block, S_INEW; a lookup passes S_LBLK and S_LHDR per block and
// S_LRD and S_LCMP per record, as the record memories have one read port.
// Reset is synchronous; tables clear at once through valid bits, no sweep.
// A stalled output holds the back part; the two-entry queue keeps the front
// accepting meanwhile.
module static_hash_overflow_chain_table_unit #(
    parameter int MAX_BUCKETS       = shk_pkg::DEF_MAX_BUCKETS,
    parameter int MAX_BLOCKS        = shk_pkg::DEF_MAX_BLOCKS,
    parameter int RECORDS_PER_BLOCK = shk_pkg::DEF_RECORDS_PER_BLOCK,
    parameter int PAYLOAD_BITS      = shk_pkg::DEF_PAYLOAD_BITS
) (
    input  logic                          i_clk,
    input  logic                          i_rst_n,
    input  logic                          i_cfg_we,
    input  logic [shk_pkg::CFG_W-1:0]     i_cfg_wdata,
    input  logic                          i_in_valid,
    output logic                          o_in_stall,
    input  logic                          i_action,
    input  logic [shk_pkg::KEY_W-1:0]     i_record_key,
    input  logic [shk_pkg::PAYLOAD_W-1:0] i_record_payload,
    output logic                          o_out_valid,
    input  logic                          i_out_stall,
    output logic [shk_pkg::STATUS_W-1:0]  o_status,
    output logic [shk_pkg::BLKNUM_W-1:0]  o_block_number,
    output logic [shk_pkg::BLKREAD_W-1:0] o_blocks_read,
    output logic [shk_pkg::PAYLOAD_W-1:0] o_found_payload
);

    // Usable bucket limit and the widths that follow from it.
    localparam int LIMIT  = (MAX_BUCKETS < MAX_BLOCKS - 1) ? MAX_BUCKETS : MAX_BLOCKS - 1;
    localparam int BW     = $clog2(LIMIT + 1);
    localparam int HW     = $clog2(MAX_BUCKETS > 1 ? MAX_BUCKETS : 2);
    localparam int QW     = 1 + shk_pkg::KEY_W + PAYLOAD_BITS + HW;
    localparam int BIU_W  = $clog2(MAX_BLOCKS + 1);
    localparam int B_RST  = (shk_pkg::RESET_BUCKETS > LIMIT) ? LIMIT : shk_pkg::RESET_BUCKETS;

    logic [BW-1:0]    r_buckets;
    logic [BW-1:0]    n_buckets;
    logic             w_push;
    logic             w_full;
    logic [QW-1:0]    w_push_data;
    logic             w_pop;
    logic             w_q_valid;
    logic [QW-1:0]    w_q_data;

    // A written bucket count is clamped into the usable range.
    always_comb begin
        if (i_cfg_wdata == '0) begin
            n_buckets = BW'(1);
        end else if (32'(i_cfg_wdata) > LIMIT) begin
            n_buckets = BW'(LIMIT);
        end else begin
            n_buckets = BW'(i_cfg_wdata);
        end
    end

    always_ff @(posedge i_clk) begin
        if (!i_rst_n) begin
            r_buckets <= BW'(B_RST);
        end else if (i_cfg_we) begin
            r_buckets <= n_buckets;
        end
    end

    shk_front #(
        .MAX_BUCKETS  (MAX_BUCKETS),
        .PAYLOAD_BITS (PAYLOAD_BITS),
        .BW           (BW),
        .QW           (QW)
    ) u_front (
        .i_clk            (i_clk),
        .i_rst_n          (i_rst_n),
        .i_buckets        (r_buckets),
        .i_in_valid       (i_in_valid),
        .o_in_stall       (o_in_stall),
        .i_action         (i_action),
        .i_record_key     (i_record_key),
        .i_record_payload (i_record_payload),
        .o_push           (w_push),
        .o_data           (w_push_data),
        .i_full           (w_full)
    );

    shk_fifo #(
        .W (QW)
    ) u_fifo (
        .i_clk   (i_clk),
        .i_rst_n (i_rst_n),
        .i_push  (w_push),
        .i_data  (w_push_data),
        .o_full  (w_full),
        .i_pop   (w_pop),
        .o_valid (w_q_valid),
        .o_data  (w_q_data)
    );

    shk_back #(
        .MAX_BUCKETS       (MAX_BUCKETS),
        .MAX_BLOCKS        (MAX_BLOCKS),
        .RECORDS_PER_BLOCK (RECORDS_PER_BLOCK),
        .PAYLOAD_BITS      (PAYLOAD_BITS),
        .QW                (QW),
        .BIU_W             (BIU_W),
        .BIU_RESET         (B_RST + 1)
    ) u_back (
        .i_clk           (i_clk),
        .i_rst_n         (i_rst_n),
        .i_clear         (i_cfg_we),
        .i_biu_init      (BIU_W'(32'(n_buckets) + 1)),
        .i_q_valid       (w_q_valid),
        .i_q_data        (w_q_data),
        .o_q_pop         (w_pop),
        .o_out_valid     (o_out_valid),
        .i_out_stall     (i_out_stall),
        .o_status        (o_status),
        .o_block_number  (o_block_number),
        .o_blocks_read   (o_blocks_read),
        .o_found_payload (o_found_payload)
    );

endmodule

[sv/shk_checker.sv]
// ============================================================================
// shk_checker: port-level checks for the hash table unit
// Watches result fields against their status and the output handshake.
// ============================================================================
module shk_checker (
    input logic                          i_clk,
    input logic                          i_rst_n,
    input logic                          o_out_valid,
    input logic                          i_out_stall,
    input logic [shk_pkg::STATUS_W-1:0]  o_status,
    input logic [shk_pkg::BLKNUM_W-1:0]  o_block_number,
    input logic [shk_pkg::BLKREAD_W-1:0] o_blocks_read,
    input logic [shk_pkg::PAYLOAD_W-1:0] o_found_payload
);

    // A stalled result keeps its status.
    a_hold: assert property (@(posedge i_clk) disable iff (!i_rst_n)
        o_out_valid && i_out_stall |=> o_out_valid && $stable(o_status))
        else $error("result changed while stalled");

    // A found record was read from at least one block.
    a_found: assert property (@(posedge i_clk) disable iff (!i_rst_n)
        o_out_valid && o_status == shk_pkg::ST_FOUND |-> o_blocks_read != '0)
        else $error("found result with no blocks read");

    // Inserts report no lookup fields.
    a_ins: assert property (@(posedge i_clk) disable iff (!i_rst_n)
        o_out_valid && o_status == shk_pkg::ST_INSERTED
        |-> o_blocks_read == '0 && o_found_payload == '0)
        else $error("insert result carries lookup fields");

    // Misses and full stores report all fields zero.
    a_miss: assert property (@(posedge i_clk) disable iff (!i_rst_n)
        o_out_valid && (o_status == shk_pkg::ST_NOT_FOUND || o_status == shk_pkg::ST_FULL)
        |-> o_block_number == '0 && o_blocks_read == '0 && o_found_payload == '0)
        else $error("empty result carries data");

endmodule

bind static_hash_overflow_chain_table_unit shk_checker u_shk_checker (
    .i_clk           (i_clk),
    .i_rst_n         (i_rst_n),
    .o_out_valid     (o_out_valid),
    .i_out_stall     (i_out_stall),
    .o_status        (o_status),
    .o_block_number  (o_block_number),
    .o_blocks_read   (o_blocks_read),
    .o_found_payload (o_found_payload)
);
